/* hdl/dpht_pkg.sv */
// ----------------------------------------------------------------------------
// dpht_pkg
// Types and codes shared by the depth-preferred hash table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dpht_pkg;

    localparam int KEY_W   = 64;
    localparam int MOVE_W  = 16;
    localparam int SCORE_W = 16;
    localparam int DEPTH_W = 8;
    localparam int BOUND_W = 2;
    localparam int ACT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_PROBE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STORE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [BOUND_W-1:0] BND_NONE  = 2'd0;
    localparam logic [BOUND_W-1:0] BND_EXACT = 2'd1;

    typedef struct packed {
        logic [MOVE_W-1:0]  move;
        logic [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0] depth;
        logic [BOUND_W-1:0] bound;
    } t_payload;

    localparam int PAYLOAD_W = $bits(t_payload);

    typedef struct packed {
        logic hit;
        logic overwrite;
    } t_verdict;

endpackage

`default_nettype wire

/* hdl/dpht_ram.sv */
// ----------------------------------------------------------------------------
// dpht_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dpht_ram #(
    parameter int WIDTH     = 64,
    parameter int ADDR_BITS = 12
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [0:(1<<ADDR_BITS)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hdl/dpht_decide.sv */
// ----------------------------------------------------------------------------
// dpht_decide
// Hit check for probes and depth-preferred replacement test for stores.
// ----------------------------------------------------------------------------
`default_nettype none

module dpht_decide (
    input  wire logic [dpht_pkg::ACT_W-1:0]   i_action,
    input  wire logic [dpht_pkg::KEY_W-1:0]   i_key,
    input  wire logic [dpht_pkg::DEPTH_W-1:0] i_depth,
    input  wire logic [dpht_pkg::BOUND_W-1:0] i_bound,
    input  wire logic [dpht_pkg::KEY_W-1:0]   i_tag,
    input  wire dpht_pkg::t_payload           i_entry,
    output dpht_pkg::t_verdict                o_verdict
);

    logic tag_eq;
    logic keep;

    assign tag_eq = (i_tag == i_key);
    assign keep   = tag_eq && (i_entry.depth > i_depth) && (i_bound != dpht_pkg::BND_EXACT);

    always_comb begin
        o_verdict.hit       = (i_action == dpht_pkg::ACT_PROBE) && tag_eq &&
                              (i_entry.bound != dpht_pkg::BND_NONE);
        o_verdict.overwrite = (i_action == dpht_pkg::ACT_STORE) && !keep;
    end

endmodule

`default_nettype wire

/* hdl/depth_preferred_hash_table.sv */
// ----------------------------------------------------------------------------
// depth_preferred_hash_table
// Direct-mapped transposition table with depth-preferred replacement.
// ----------------------------------------------------------------------------
//  channel  | handshake            | word
//  ---------+----------------------+------------------------------------------
//  request  | start, busy          | i_action, i_lookup_key, i_entry_*
//  result   | o_valid (one cycle)  | o_hit, o_hit_*, o_written
//
//  Probe, store and unused action: accepted, memory read as the word is taken,
//  decided in S_LOOK, result strobed as S_LOOK ends; busy holds off a new word
//  until then (read, then decide and write back through one memory port pair).
//  Clear: sweeps 2^INDEX_BITS entries, one a cycle, result after the sweep.
//  Reset: the same sweep of 2^INDEX_BITS entries runs with busy high, no result.
//  The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_preferred_hash_table #(
    parameter int INDEX_BITS = 12
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic        [dpht_pkg::ACT_W-1:0]    i_action,
    input  wire logic        [dpht_pkg::KEY_W-1:0]    i_lookup_key,
    input  wire logic        [dpht_pkg::MOVE_W-1:0]   i_entry_move,
    input  wire logic signed [dpht_pkg::SCORE_W-1:0]  i_entry_score,
    input  wire logic        [dpht_pkg::DEPTH_W-1:0]  i_entry_depth,
    input  wire logic        [dpht_pkg::BOUND_W-1:0]  i_entry_bound,
    output logic                                      o_valid,
    output logic                                      o_hit,
    output logic             [dpht_pkg::MOVE_W-1:0]   o_hit_move,
    output logic signed      [dpht_pkg::SCORE_W-1:0]  o_hit_score,
    output logic             [dpht_pkg::DEPTH_W-1:0]  o_hit_depth,
    output logic             [dpht_pkg::BOUND_W-1:0]  o_hit_bound,
    output logic                                      o_written
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_state;

    t_state                          r_state;
    logic [INDEX_BITS-1:0]           r_addr;
    logic                            r_report;
    logic [dpht_pkg::ACT_W-1:0]      r_action;
    logic [dpht_pkg::KEY_W-1:0]      r_key;
    dpht_pkg::t_payload              r_req;

    logic [dpht_pkg::KEY_W-1:0]      tag_rd;
    dpht_pkg::t_payload              entry_rd;
    logic [dpht_pkg::PAYLOAD_W-1:0]  entry_bits;
    dpht_pkg::t_verdict              verdict;

    logic                            accept;
    logic                            mem_we;
    logic [INDEX_BITS-1:0]           mem_waddr;
    logic [dpht_pkg::KEY_W-1:0]      tag_wdata;
    logic [dpht_pkg::PAYLOAD_W-1:0]  entry_wdata;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign entry_rd = dpht_pkg::t_payload'(entry_bits);

    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we      = 1'b1;
            mem_waddr   = r_addr;
            tag_wdata   = '0;
            entry_wdata = '0;
        end else begin
            mem_we      = (r_state == S_LOOK) && verdict.overwrite;
            mem_waddr   = r_key[INDEX_BITS-1:0];
            tag_wdata   = r_key;
            entry_wdata = r_req;
        end
    end

    dpht_ram #(
        .WIDTH     (dpht_pkg::KEY_W),
        .ADDR_BITS (INDEX_BITS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (tag_wdata),
        .i_raddr (i_lookup_key[INDEX_BITS-1:0]),
        .o_rdata (tag_rd)
    );

    dpht_ram #(
        .WIDTH     (dpht_pkg::PAYLOAD_W),
        .ADDR_BITS (INDEX_BITS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (entry_wdata),
        .i_raddr (i_lookup_key[INDEX_BITS-1:0]),
        .o_rdata (entry_bits)
    );

    dpht_decide u_decide (
        .i_action  (r_action),
        .i_key     (r_key),
        .i_depth   (r_req.depth),
        .i_bound   (r_req.bound),
        .i_tag     (tag_rd),
        .i_entry   (entry_rd),
        .o_verdict (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_report    <= 1'b0;
            o_valid     <= 1'b0;
            o_hit       <= 1'b0;
            o_hit_move  <= '0;
            o_hit_score <= '0;
            o_hit_depth <= '0;
            o_hit_bound <= '0;
            o_written   <= 1'b0;
        end else begin
            o_valid     <= 1'b0;
            o_hit       <= 1'b0;
            o_hit_move  <= '0;
            o_hit_score <= '0;
            o_hit_depth <= '0;
            o_hit_bound <= '0;
            o_written   <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == {INDEX_BITS{1'b1}}) begin
                        r_state   <= S_IDLE;
                        o_valid   <= r_report;
                        o_written <= r_report;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_action    <= i_action;
                        r_key       <= i_lookup_key;
                        r_req.move  <= i_entry_move;
                        r_req.score <= i_entry_score;
                        r_req.depth <= i_entry_depth;
                        r_req.bound <= i_entry_bound;
                        if (i_action == dpht_pkg::ACT_CLEAR) begin
                            r_state  <= S_CLEAR;
                            r_addr   <= '0;
                            r_report <= 1'b1;
                        end else begin
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    r_state   <= S_IDLE;
                    o_valid   <= 1'b1;
                    o_written <= verdict.overwrite;
                    if (verdict.hit) begin
                        o_hit       <= 1'b1;
                        o_hit_move  <= entry_rd.move;
                        o_hit_score <= entry_rd.score;
                        o_hit_depth <= entry_rd.depth;
                        o_hit_bound <= entry_rd.bound;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted word did not raise busy");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result strobe outside end of operation");

    a_hit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> (o_valid && !o_written && (o_hit_bound != dpht_pkg::BND_NONE)))
        else $error("hit with write or empty bound");

    a_write_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && r_action == dpht_pkg::ACT_PROBE) |-> !mem_we)
        else $error("probe wrote memory");

endmodule

`default_nettype wire
